/* src/hwtrl_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the wet-time logger.
package hwtrl_pkg;

	localparam int RING_HOURS_DEF = 2048;
	localparam int SECS_PER_HOUR  = 3600;

	localparam int HOUR_W = 21;
	localparam int TIME_W = 32;
	localparam int SECS_W = 12;
	localparam int CLR_W  = 13;
	localparam int STAT_W = 3;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// epoch / 3600 == (epoch >> 4) / 225, done as a reciprocal multiply
	localparam int              DIV_PRE_SHIFT = 4;
	localparam int              DIV_MUL_W     = 29;
	localparam int              P1_W          = TIME_W - DIV_PRE_SHIFT + DIV_MUL_W;
	localparam logic [DIV_MUL_W-1:0] DIV3600_MUL = 29'd305419897;
	localparam int              DIV3600_SHIFT = 36;

	// hour % ring size uses a reciprocal with this shift
	localparam int MOD_SHIFT = 34;

	localparam logic [STAT_W-1:0] RES_IGNORED = 3'd0;
	localparam logic [STAT_W-1:0] RES_STARTED = 3'd1;
	localparam logic [STAT_W-1:0] RES_ACCUM   = 3'd2;
	localparam logic [STAT_W-1:0] RES_COMMIT  = 3'd3;
	localparam logic [STAT_W-1:0] RES_READ    = 3'd4;

	typedef struct packed {
		logic enable;
		logic [TIME_W-1:0] min_epoch;
	} hwtrl_cfg_t;

	typedef struct packed {
		logic load;
		logic hour;
		logic moda;
		logic modb;
		logic exec;
		logic sweep;
		logic finish;
	} hwtrl_cmd_t;

	typedef struct packed {
		logic clear_req;
		logic sweep_last;
		logic out_free;
	} hwtrl_sts_t;

endpackage

/* src/hourly_wet_time_ring_logger_unit.sv */
// Hourly wet-time ring logger: samples accumulate wet seconds per hour into a ring of
// RING_HOURS slots, reads return one hour's count. After reset the block zeroes the ring
// one slot per cycle and takes no request until that sweep ends (configuration writes are
// taken at once). A request is then loaded, goes through the hour and slot arithmetic (a
// reciprocal multiply for the division by 3600 and two multiplies for the ring-size
// modulo), updates state and hands off the result once the output register is free.
// A sample that skips hours zeroes the skipped slots one per cycle on the single ring
// write port, up to RING_HOURS, before the hand-off. The next request is accepted while
// a result still waits in the output register.
module hourly_wet_time_ring_logger_unit import hwtrl_pkg::*; #(
	parameter int RING_HOURS = RING_HOURS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              func,
	input  logic [TIME_W-1:0] epoch_seconds,
	input  logic              wet,
	input  logic [HOUR_W-1:0] read_hour,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [STAT_W-1:0] status,
	output logic [SECS_W-1:0] wet_seconds,
	output logic [CLR_W-1:0]  hours_cleared,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	hwtrl_cfg_t cfg;
	hwtrl_cmd_t cmd;
	hwtrl_sts_t sts;

	assign pready = 1'b1;

	hwtrl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	hwtrl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	hwtrl_dp #(
		.RING_HOURS (RING_HOURS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd           (cmd),
		.sts           (sts),
		.func          (func),
		.epoch_seconds (epoch_seconds),
		.wet           (wet),
		.read_hour     (read_hour),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.wet_seconds   (wet_seconds),
		.hours_cleared (hours_cleared)
	);

endmodule

/* src/hwtrl_regs.sv */
// APB-style configuration registers: logging enable and minimum valid epoch.
module hwtrl_regs import hwtrl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output hwtrl_cfg_t        cfg
);

	localparam logic REG_ENABLE    = 1'b0;
	localparam logic REG_MIN_EPOCH = 1'b1;

	logic              enable_q;
	logic [TIME_W-1:0] min_epoch_q;
	logic              wr_en;

	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			min_epoch_q <= '0;
		end else if (wr_en) begin
			case (paddr[2])
				REG_ENABLE:    enable_q    <= pwdata[0];
				REG_MIN_EPOCH: min_epoch_q <= pwdata;
				default:       enable_q    <= enable_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_ENABLE:    prdata = {{(DATA_W-1){1'b0}}, enable_q};
			REG_MIN_EPOCH: prdata = min_epoch_q;
			default:       prdata = '0;
		endcase
	end

	assign cfg.enable    = enable_q;
	assign cfg.min_epoch = min_epoch_q;

endmodule

/* src/hwtrl_ctrl.sv */
// Controller state machine: sequences request load, hour/slot arithmetic, update and ring sweeps.
module hwtrl_ctrl import hwtrl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  hwtrl_sts_t sts,
	output hwtrl_cmd_t cmd
);

	localparam logic [2:0] S_INIT  = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_HOUR  = 3'd2;
	localparam logic [2:0] S_MODA  = 3'd3;
	localparam logic [2:0] S_MODB  = 3'd4;
	localparam logic [2:0] S_EXEC  = 3'd5;
	localparam logic [2:0] S_SWEEP = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		case (state_q)
			S_INIT: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_HOUR;
				end
			end
			S_HOUR: begin
				cmd.hour = 1'b1;
				state_d  = S_MODA;
			end
			S_MODA: begin
				cmd.moda = 1'b1;
				state_d  = S_MODB;
			end
			S_MODB: begin
				cmd.modb = 1'b1;
				state_d  = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.clear_req ? S_SWEEP : S_DONE;
			end
			S_SWEEP: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) state_d = S_DONE;
			end
			S_DONE: begin
				// hold until the output register can take the result
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* src/hwtrl_dp.sv */
// Datapath: hour arithmetic, accumulator state, wet-seconds ring memory and output register.
module hwtrl_dp import hwtrl_pkg::*; #(
	parameter int RING_HOURS = RING_HOURS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  hwtrl_cfg_t        cfg,
	input  hwtrl_cmd_t        cmd,
	output hwtrl_sts_t        sts,
	input  logic              func,
	input  logic [TIME_W-1:0] epoch_seconds,
	input  logic              wet,
	input  logic [HOUR_W-1:0] read_hour,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [STAT_W-1:0] status,
	output logic [SECS_W-1:0] wet_seconds,
	output logic [CLR_W-1:0]  hours_cleared
);

	localparam int SLOT_W = $clog2(RING_HOURS);
	localparam int CNT_W  = $clog2(RING_HOURS + 1);
	localparam longint unsigned MOD_MUL =
		((64'd1 << MOD_SHIFT) + 64'(RING_HOURS) - 64'd1) / 64'(RING_HOURS);
	localparam int MOD_MUL_W = $clog2(MOD_MUL + 1);
	localparam int P2_W      = HOUR_W + MOD_MUL_W;
	localparam int Q_W       = P2_W - MOD_SHIFT;
	localparam logic [MOD_MUL_W-1:0] MOD_MUL_C = MOD_MUL_W'(MOD_MUL);
	localparam logic [HOUR_W-1:0]    RING_H    = HOUR_W'(RING_HOURS);
	localparam logic [CNT_W-1:0]     RING_C    = CNT_W'(RING_HOURS);
	localparam logic [SLOT_W-1:0]    SLOT_LAST = SLOT_W'(RING_HOURS - 1);
	localparam logic [SECS_W-1:0]    HOUR_SECS = SECS_W'(SECS_PER_HOUR);

	// request payload
	logic              in_func_q;
	logic [TIME_W-1:0] in_time_q;
	logic              in_wet_q;
	logic [HOUR_W-1:0] in_rh_q;

	// arithmetic stages
	logic [P1_W-1:0]   p1_q;
	logic [HOUR_W-1:0] hour_q;
	logic [P2_W-1:0]   p2_q;
	logic [HOUR_W-1:0] p3_q;

	// logger state
	logic [HOUR_W-1:0] cur_hour_q;
	logic [HOUR_W-1:0] last_commit_q;
	logic [SECS_W-1:0] acc_q;
	logic [TIME_W-1:0] last_time_q;
	logic [SLOT_W-1:0] cur_slot_q;
	logic [SLOT_W-1:0] idx_q;
	logic [CNT_W-1:0]  cnt_q;

	// result holding
	logic [STAT_W-1:0] res_status_q;
	logic [SECS_W-1:0] res_secs_q;
	logic [CLR_W-1:0]  res_clr_q;
	logic              hit_q;
	logic [SECS_W-1:0] rd_q;
	logic              out_valid_q;
	logic [STAT_W-1:0] out_status_q;
	logic [SECS_W-1:0] out_secs_q;
	logic [CLR_W-1:0]  out_clr_q;

	logic [SECS_W-1:0] wet_ring_q [RING_HOURS];

	// combinational
	logic [TIME_W-DIV_PRE_SHIFT-1:0] now_pre;
	logic [P1_W-1:0]   p1_d;
	logic [HOUR_W-1:0] mod_in;
	logic [P2_W-1:0]   p2_d;
	logic [Q_W-1:0]    quot;
	logic [HOUR_W-1:0] p3_d;
	logic [HOUR_W-1:0] rem_full;
	logic [SLOT_W-1:0] slot;
	logic              sample_ok;
	logic              started;
	logic              changed;
	logic              commit;
	logic [HOUR_W-1:0] lo;
	logic [HOUR_W:0]   lo_p1;
	logic              gap;
	logic              do_clear;
	logic [HOUR_W-1:0] gap_n;
	logic [CNT_W-1:0]  clr_n;
	logic [CNT_W:0]    slot_x;
	logic [CNT_W:0]    n_x;
	logic [CNT_W:0]    start_x;
	logic [SLOT_W-1:0] start_slot;
	logic [TIME_W-1:0] delta;
	logic              add_ok;
	logic [SECS_W:0]   sum;
	logic [SECS_W-1:0] acc_new;
	logic              mem_we;
	logic [SLOT_W-1:0] mem_waddr;
	logic [SECS_W-1:0] mem_wdata;

	assign now_pre  = in_time_q[TIME_W-1:DIV_PRE_SHIFT];
	assign p1_d     = now_pre * DIV3600_MUL;
	assign mod_in   = in_func_q ? in_rh_q : p1_q[DIV3600_SHIFT +: HOUR_W];
	assign p2_d     = mod_in * MOD_MUL_C;
	assign quot     = p2_q[P2_W-1:MOD_SHIFT];
	assign p3_d     = quot * RING_H;
	assign rem_full = hour_q - p3_q;
	assign slot     = rem_full[SLOT_W-1:0];

	assign sample_ok = !in_func_q && cfg.enable && (in_time_q >= cfg.min_epoch);
	assign started   = (cur_hour_q != '0);
	assign changed   = (hour_q != cur_hour_q);
	assign commit    = sample_ok && started && changed;

	// zero-fill the skipped hours, bounded to the ring
	assign lo       = started ? cur_hour_q : last_commit_q;
	assign lo_p1    = {1'b0, lo} + (HOUR_W+1)'(1);
	assign gap      = ({1'b0, hour_q} > lo_p1);
	assign do_clear = sample_ok && gap && (started || (last_commit_q != '0));
	assign gap_n    = hour_q - lo - HOUR_W'(1);
	assign clr_n    = (gap_n > RING_H) ? RING_C : gap_n[CNT_W-1:0];
	assign slot_x   = (CNT_W+1)'(slot);
	assign n_x      = (CNT_W+1)'(clr_n);
	assign start_x  = (slot_x >= n_x) ? (slot_x - n_x)
	                                  : (slot_x + (CNT_W+1)'(RING_HOURS) - n_x);
	assign start_slot = start_x[SLOT_W-1:0];

	// wet time since the previous sample, saturating at one hour
	assign delta   = in_time_q - last_time_q;
	assign add_ok  = in_wet_q && (in_time_q > last_time_q) &&
	                 (delta < TIME_W'(SECS_PER_HOUR));
	assign sum     = {1'b0, acc_q} + (add_ok ? {1'b0, delta[SECS_W-1:0]} : '0);
	assign acc_new = (sum > {1'b0, HOUR_SECS}) ? HOUR_SECS : sum[SECS_W-1:0];

	assign mem_we    = cmd.sweep || (cmd.exec && commit);
	assign mem_waddr = cmd.sweep ? idx_q : cur_slot_q;
	assign mem_wdata = cmd.sweep ? '0 : acc_new;

	always_ff @(posedge clk) begin
		if (mem_we) wet_ring_q[mem_waddr] <= mem_wdata;
		if (cmd.exec) rd_q <= wet_ring_q[slot];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_func_q <= func;
			in_time_q <= epoch_seconds;
			in_wet_q  <= wet;
			in_rh_q   <= read_hour;
		end
		if (cmd.hour) p1_q <= p1_d;
		if (cmd.moda) begin
			hour_q <= mod_in;
			p2_q   <= p2_d;
		end
		if (cmd.modb) p3_q <= p3_d;
		if (cmd.exec) begin
			hit_q <= !in_func_q || (in_rh_q == cur_hour_q);
			if (in_func_q) begin
				res_status_q <= RES_READ;
				res_secs_q   <= acc_q;
			end else if (!sample_ok) begin
				res_status_q <= RES_IGNORED;
				res_secs_q   <= '0;
			end else if (!started) begin
				res_status_q <= RES_STARTED;
				res_secs_q   <= '0;
			end else if (changed) begin
				res_status_q <= RES_COMMIT;
				res_secs_q   <= acc_new;
			end else begin
				res_status_q <= RES_ACCUM;
				res_secs_q   <= '0;
			end
			res_clr_q <= do_clear ? CLR_W'(clr_n) : '0;
		end
		if (cmd.finish) begin
			out_status_q <= res_status_q;
			out_secs_q   <= hit_q ? res_secs_q : rd_q;
			out_clr_q    <= res_clr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_hour_q    <= '0;
			last_commit_q <= '0;
			acc_q         <= '0;
			last_time_q   <= '0;
			cur_slot_q    <= '0;
			idx_q         <= '0;
			cnt_q         <= RING_C;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.exec && sample_ok) begin
				last_time_q <= in_time_q;
				if (!started) begin
					cur_hour_q <= hour_q;
					cur_slot_q <= slot;
				end else if (changed) begin
					last_commit_q <= cur_hour_q;
					cur_hour_q    <= hour_q;
					cur_slot_q    <= slot;
					acc_q         <= '0;
				end else begin
					acc_q <= acc_new;
				end
				if (do_clear) begin
					idx_q <= start_slot;
					cnt_q <= clr_n;
				end
			end else if (cmd.sweep) begin
				// advance one slot, wrap at the ring end
				idx_q <= (idx_q == SLOT_LAST) ? '0 : idx_q + SLOT_W'(1);
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.clear_req  = do_clear;
	assign sts.sweep_last = (cnt_q == CNT_W'(1));
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign wet_seconds   = out_secs_q;
	assign hours_cleared = out_clr_q;

endmodule

/* verif/hwtrl_tb_pkg.sv */
// Operation codes, register addresses and the result record shared by the logger testbench files.
package hwtrl_tb_pkg;

	import hwtrl_pkg::*;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_READ   = 1'b1
	} wet_op_e;

	localparam logic [ADDR_W-1:0] ADDR_LOG_ENABLE = 3'd0;
	localparam logic [ADDR_W-1:0] ADDR_MIN_EPOCH  = 3'd4;

	localparam int unsigned HOUR_SECS = SECS_PER_HOUR;
	localparam int unsigned LAST_HOUR = 32'hFFFF_FFFF / HOUR_SECS;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [SECS_W-1:0] secs;
		logic [CLR_W-1:0]  cleared;
	} wet_result_t;

endpackage

/* verif/hourly_wet_time_ring_logger_checker.sv */
// Checker for the wet-time logger: tracks configuration, predicts each result and compares.
module hourly_wet_time_ring_logger_checker import hwtrl_pkg::*; import hwtrl_tb_pkg::*; #(
	parameter int RING = RING_HOURS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic              func,
	input  logic [TIME_W-1:0] epoch_seconds,
	input  logic              wet,
	input  logic [HOUR_W-1:0] read_hour,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [STAT_W-1:0] status,
	input  logic [SECS_W-1:0] wet_seconds,
	input  logic [CLR_W-1:0]  hours_cleared,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output int                mismatches,
	output int                pending,
	output int                n_ignored,
	output int                n_started,
	output int                n_accum,
	output int                n_commit,
	output int                n_read,
	output int                widest_fill
);

	logic [SECS_W-1:0] wet_hist [RING];
	int unsigned       live_hour;
	int unsigned       commit_hour;
	int unsigned       live_secs;
	int unsigned       last_stamp;
	logic              log_en;
	logic [TIME_W-1:0] epoch_floor;
	wet_result_t       expected_results [$];

	// zero the hours strictly between lo and hi, at most one full ring
	function automatic int unsigned zero_gap(int unsigned lo, int unsigned hi);
		int unsigned n;
		int unsigned h;
		n = hi - lo - 1;
		if (n > RING)
			n = RING;
		for (h = hi - n; h < hi; h++)
			wet_hist[h % RING] = '0;
		return n;
	endfunction

	function automatic wet_result_t predict_wet_time(logic op, logic [TIME_W-1:0] t, logic w,
			logic [HOUR_W-1:0] rh);
		wet_result_t r;
		int unsigned now;
		int unsigned now_hour;
		int unsigned prev;
		int unsigned hr;
		r = '0;
		now = t;
		hr = 32'(rh);
		if (op == OP_READ) begin
			r.status = RES_READ;
			r.secs = (hr == live_hour) ? SECS_W'(live_secs) : wet_hist[hr % RING];
		end else if (log_en && t >= epoch_floor) begin
			now_hour = now / HOUR_SECS;
			if (live_hour == 0) begin
				// hour zero doubles as "not started", so any sample there restarts
				live_hour = now_hour;
				last_stamp = now;
				if (commit_hour != 0 && now_hour > commit_hour + 1)
					r.cleared = CLR_W'(zero_gap(commit_hour, now_hour));
				r.status = RES_STARTED;
			end else begin
				prev = last_stamp;
				last_stamp = now;
				if (now > prev && now - prev < HOUR_SECS && w) begin
					live_secs += now - prev;
					if (live_secs > HOUR_SECS)
						live_secs = HOUR_SECS;
				end
				r.status = RES_ACCUM;
				if (now_hour != live_hour) begin
					r.secs = SECS_W'(live_secs);
					wet_hist[live_hour % RING] = SECS_W'(live_secs);
					commit_hour = live_hour;
					if (now_hour > live_hour + 1)
						r.cleared = CLR_W'(zero_gap(live_hour, now_hour));
					live_hour = now_hour;
					live_secs = 0;
					r.status = RES_COMMIT;
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		wet_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < RING; i++)
				wet_hist[i] = '0;
			live_hour = 0;
			commit_hour = 0;
			live_secs = 0;
			last_stamp = 0;
			log_en = 1'b0;
			epoch_floor = '0;
			expected_results.delete();
			mismatches = 0;
			pending = 0;
			n_ignored = 0;
			n_started = 0;
			n_accum = 0;
			n_commit = 0;
			n_read = 0;
			widest_fill = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr)
					ADDR_LOG_ENABLE: log_en = pwdata[0];
					ADDR_MIN_EPOCH:  epoch_floor = pwdata[TIME_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_results.push_back(predict_wet_time(func, epoch_seconds, wet, read_hour));
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result with no request waiting: status %0d wet_seconds %0d cleared %0d",
						status, wet_seconds, hours_cleared);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						mismatches++;
					end
					if (wet_seconds !== want.secs) begin
						$error("wet_seconds: expected %0d, got %0d", want.secs, wet_seconds);
						mismatches++;
					end
					if (hours_cleared !== want.cleared) begin
						$error("hours_cleared: expected %0d, got %0d", want.cleared, hours_cleared);
						mismatches++;
					end
					case (want.status)
						RES_IGNORED: n_ignored++;
						RES_STARTED: n_started++;
						RES_ACCUM:   n_accum++;
						RES_COMMIT:  n_commit++;
						default:     n_read++;
					endcase
					if (int'(want.cleared) > widest_fill)
						widest_fill = int'(want.cleared);
				end
			end
			pending = expected_results.size();
		end
	end

endmodule

/* verif/hourly_wet_time_ring_logger_unit_tb.sv */
// Testbench top for the wet-time logger: drives requests and configuration, reports the verdict.
module hourly_wet_time_ring_logger_unit_tb;

	import hwtrl_pkg::*;
	import hwtrl_tb_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic              func;
	logic [TIME_W-1:0] epoch_seconds;
	logic              wet;
	logic [HOUR_W-1:0] read_hour;
	logic              out_valid;
	logic              out_ready;
	logic [STAT_W-1:0] status;
	logic [SECS_W-1:0] wet_seconds;
	logic [CLR_W-1:0]  hours_cleared;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int mismatches;
	int pending;
	int n_ignored;
	int n_started;
	int n_accum;
	int n_commit;
	int n_read;
	int widest_fill;

	bit                no_idle;
	bit                hold_out;
	logic              cur_en;
	logic [TIME_W-1:0] cur_floor;
	logic [TIME_W-1:0] clock_now;
	int                big_jumps_left;

	hourly_wet_time_ring_logger_unit DUT (.*);

	hourly_wet_time_ring_logger_checker u_checker (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#12_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_out) begin
				out_ready <= 1'b0;
				repeat (400) @(negedge clk);
				hold_out = 1'b0;
			end else if (!no_idle && $urandom_range(0, 6) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(0, 9)) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic offer(input wet_op_e op, input logic [TIME_W-1:0] t, input logic w,
			input logic [HOUR_W-1:0] rh);
		int gap;
		@(negedge clk);
		if (!no_idle && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 10);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		func <= op;
		epoch_seconds <= t;
		wet <= w;
		read_hour <= rh;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_all_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// registers change only with the block drained
	task automatic configure(input logic en, input logic [TIME_W-1:0] floor_val);
		wait_all_results();
		reg_write(ADDR_LOG_ENABLE, DATA_W'(en));
		reg_write(ADDR_MIN_EPOCH, floor_val);
		cur_en = en;
		cur_floor = floor_val;
	endtask

	// mostly a steadily advancing clock with reads of nearby hours; some jumps and noise
	task automatic random_traffic(input int target);
		int          useful;
		int          pick;
		int unsigned hr_now;
		int unsigned back;
		logic [HOUR_W-1:0] rh;
		useful = 0;
		while (useful < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				hr_now = clock_now / HOUR_SECS;
				case ($urandom_range(0, 3))
					0: back = 0;
					1: back = $urandom_range(1, 30);
					2: back = $urandom_range(0, RING_HOURS_DEF + 100);
					default: back = hr_now + 1;
				endcase
				if (back > hr_now)
					rh = HOUR_W'($urandom_range(0, LAST_HOUR));
				else
					rh = HOUR_W'(hr_now - back);
				offer(OP_READ, $urandom, 1'($urandom_range(0, 1)), rh);
				useful++;
			end else begin
				if (pick < 75) begin
					clock_now += $urandom_range(1, 900);
				end else if (pick < 83) begin
					clock_now += $urandom_range(HOUR_SECS, 6 * HOUR_SECS);
				end else if (pick < 88) begin
					back = $urandom_range(0, 200);
					if (clock_now > back)
						clock_now -= back;
				end else if (pick < 93) begin
					back = $urandom_range(HOUR_SECS, 4 * HOUR_SECS);
					if (clock_now > back)
						clock_now -= back;
				end else if (pick < 96 && big_jumps_left > 0) begin
					// each of these may sweep the whole ring, so keep them rare
					big_jumps_left--;
					if ($urandom_range(0, 1))
						clock_now = $urandom;
					else
						clock_now += HOUR_SECS *
							$urandom_range(RING_HOURS_DEF, RING_HOURS_DEF + 1500);
				end else begin
					clock_now += $urandom_range(1, 900);
				end
				offer(OP_SAMPLE, clock_now, $urandom_range(0, 3) != 0, HOUR_W'($urandom));
				if (cur_en && clock_now >= cur_floor)
					useful++;
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = OP_SAMPLE;
		epoch_seconds = '0;
		wet = 1'b0;
		read_hour = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		no_idle = 1'b0;
		hold_out = 1'b0;
		cur_en = 1'b0;
		cur_floor = '0;
		clock_now = '0;
		big_jumps_left = 20;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// directed: reset state, disabled logging, hour zero, saturation, gaps, extremes
		offer(OP_READ, '0, 1'b0, '0);
		offer(OP_SAMPLE, 32'd5000, 1'b1, '0);
		configure(1'b1, '0);
		offer(OP_SAMPLE, 32'd0, 1'b1, '0);
		offer(OP_SAMPLE, 32'd100, 1'b1, '0);
		offer(OP_SAMPLE, 32'd3599, 1'b1, '0);
		offer(OP_SAMPLE, 5 * HOUR_SECS + 1, 1'b1, '0);
		offer(OP_SAMPLE, 5 * HOUR_SECS + 1, 1'b1, '0);
		offer(OP_SAMPLE, 6 * HOUR_SECS - 1, 1'b1, '0);
		offer(OP_SAMPLE, 5 * HOUR_SECS + 1, 1'b0, '0);
		offer(OP_SAMPLE, 6 * HOUR_SECS - 1, 1'b1, '0);
		offer(OP_READ, '0, 1'b0, 21'd5);
		offer(OP_READ, '0, 1'b0, 21'd6);
		offer(OP_SAMPLE, 6 * HOUR_SECS, 1'b1, '0);
		offer(OP_SAMPLE, 9 * HOUR_SECS, 1'b1, '0);
		offer(OP_READ, '0, 1'b1, 21'd5);
		offer(OP_SAMPLE, 3 * HOUR_SECS + 7, 1'b1, '0);
		offer(OP_SAMPLE, 3003 * HOUR_SECS, 1'b1, '0);
		offer(OP_SAMPLE, 32'd0, 1'b1, '0);
		offer(OP_SAMPLE, 5200 * HOUR_SECS, 1'b0, '0);
		offer(OP_SAMPLE, 32'hFFFF_FFFF, 1'b1, '0);
		offer(OP_READ, '0, 1'b0, HOUR_W'(LAST_HOUR));
		configure(1'b1, 32'hFFFF_FFFF);
		offer(OP_SAMPLE, 32'hFFFF_FFFE, 1'b1, '0);
		offer(OP_SAMPLE, 32'hFFFF_FFFF, 1'b1, '0);
		configure(1'b1, 32'd500000);
		offer(OP_SAMPLE, 32'd499999, 1'b1, '0);
		offer(OP_SAMPLE, 32'd500000, 1'b1, '0);

		// random phases over several register settings
		configure(1'b1, '0);
		clock_now = $urandom_range(10 * HOUR_SECS, 32'hD000_0000);
		random_traffic(150);

		// samples start below the floor; hold the result side so the block backs up
		configure(1'b1, clock_now + 30000);
		hold_out = 1'b1;
		random_traffic(120);

		configure(1'b0, $urandom);
		random_traffic(8);

		configure(1'b1, '0);
		clock_now = $urandom;
		random_traffic(150);

		configure(1'b1, '0);
		no_idle = 1'b1;
		random_traffic(160);

		wait_all_results();
		repeat (20) @(negedge clk);
		$display("covered %0d results: %0d ignored, %0d started, %0d accumulated, %0d reads",
			n_ignored + n_started + n_accum + n_commit + n_read,
			n_ignored, n_started, n_accum, n_read);
		$display("%0d hour commits, widest zero-fill %0d slots", n_commit, widest_fill);
		if (mismatches == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
